// ----- design/ndlg_pkg.sv -----
// ndlg_pkg: shared types and constants for the nearest downscale luma glyph block.
// Used by ndlg_sampler, ndlg_glyph and nearest_downscale_luma_glyph_core.
`timescale 1ns / 1ps

package ndlg_pkg;

	localparam int CFG_W = 13;
	localparam int IDX_W = 2;
	localparam int IN_W  = 24;
	localparam int OUT_W = 40;
	localparam int GLYPH_W = 7;
	localparam int LEVEL_W = 4;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_TGT_WIDTH  = 2'd2;
	localparam logic [IDX_W-1:0] REG_TGT_HEIGHT = 2'd3;

	localparam int RST_SRC_WIDTH  = 640;
	localparam int RST_SRC_HEIGHT = 480;
	localparam int RST_TGT_WIDTH  = 80;
	localparam int RST_TGT_HEIGHT = 24;

	// luma = (28r + 65g + 7b) / 100, level = floor(9 * luma / 255)
	localparam int LUMA_R    = 28;
	localparam int LUMA_G    = 65;
	localparam int LUMA_B    = 7;
	localparam int LEVEL_MUL = 9;
	localparam int LEVEL_DIV = 25500;
	localparam int LEVEL_MAX = 9;

	typedef struct packed {
		logic       row_end;
		logic       frame_end;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} sample_t;

	// "@%#*+=-:. " darkest to brightest
	function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
		logic [GLYPH_W-1:0] g;
		case (lvl)
			4'd0: g = 7'd64;
			4'd1: g = 7'd37;
			4'd2: g = 7'd35;
			4'd3: g = 7'd42;
			4'd4: g = 7'd43;
			4'd5: g = 7'd61;
			4'd6: g = 7'd45;
			4'd7: g = 7'd58;
			4'd8: g = 7'd46;
			default: g = 7'd32;
		endcase
		return g;
	endfunction

endpackage

// ----- design/ndlg_sampler.sv -----
// ndlg_sampler: size registers, source/output position counters and the sampling test.
// Registers each sampled pixel into stage 1. Depends on ndlg_pkg.
`timescale 1ns / 1ps

module ndlg_sampler #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ndlg_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ndlg_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ndlg_pkg::IN_W-1:0]      s_tdata,
	input  logic                           take,
	output logic                           smp_vld_s1,
	output ndlg_pkg::sample_t              smp_s1
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int ACC_W = 2 * DIM_W + 1;
	localparam int CMP_W = (DIM_W > ndlg_pkg::CFG_W) ? DIM_W : ndlg_pkg::CFG_W;

	localparam int RST_W   = (ndlg_pkg::RST_SRC_WIDTH > MAX_DIM) ? MAX_DIM
		: ndlg_pkg::RST_SRC_WIDTH;
	localparam int RST_H   = (ndlg_pkg::RST_SRC_HEIGHT > MAX_DIM) ? MAX_DIM
		: ndlg_pkg::RST_SRC_HEIGHT;
	localparam int RST_TWR = (ndlg_pkg::RST_TGT_WIDTH > MAX_DIM) ? MAX_DIM
		: ndlg_pkg::RST_TGT_WIDTH;
	localparam int RST_THR = (ndlg_pkg::RST_TGT_HEIGHT > MAX_DIM) ? MAX_DIM
		: ndlg_pkg::RST_TGT_HEIGHT;
	localparam int RST_TW  = (RST_TWR > RST_W) ? RST_W : RST_TWR;
	localparam int RST_TH  = (RST_THR > RST_H) ? RST_H : RST_THR;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [ndlg_pkg::CFG_W-1:0] v);
		logic [CMP_W-1:0] x;
		logic [DIM_W-1:0] d;
		x = CMP_W'(v);
		if (x == '0) begin
			d = DIM_W'(1);
		end else if (x > CMP_W'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(x);
		end
		return d;
	endfunction

	// effective sizes; raw targets are kept clamped only to the legal range
	logic [DIM_W-1:0] w_q, h_q, twr_q, thr_q, tw_q, th_q;
	logic [DIM_W-1:0] w_n, h_n, twr_n, thr_n, tw_n, th_n;

	logic [DIM_W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;
	logic [ACC_W-1:0] cnum_q, cthr_q, rnum_q, rthr_q;

	logic accept, row_hit, col_hit, col_last, row_last, out_col_last, out_row_last;

	always_comb begin
		w_n   = w_q;
		h_n   = h_q;
		twr_n = twr_q;
		thr_n = thr_q;
		case (cfg_index)
			ndlg_pkg::REG_SRC_WIDTH:  w_n   = clamp_dim(cfg_data);
			ndlg_pkg::REG_SRC_HEIGHT: h_n   = clamp_dim(cfg_data);
			ndlg_pkg::REG_TGT_WIDTH:  twr_n = clamp_dim(cfg_data);
			ndlg_pkg::REG_TGT_HEIGHT: thr_n = clamp_dim(cfg_data);
			default: ;
		endcase
		tw_n = (twr_n > w_n) ? w_n : twr_n;
		th_n = (thr_n > h_n) ? h_n : thr_n;
	end

	assign accept       = s_tvalid && s_tready;
	assign s_tready     = !smp_vld_s1 || take;
	assign row_hit      = (out_row_q < th_q) && (rnum_q < rthr_q);
	assign col_hit      = row_hit && (out_col_q < tw_q) && (cnum_q < cthr_q);
	assign col_last     = (src_col_q + DIM_W'(1)) == w_q;
	assign row_last     = (src_row_q + DIM_W'(1)) == h_q;
	assign out_col_last = (out_col_q + DIM_W'(1)) == tw_q;
	assign out_row_last = (out_row_q + DIM_W'(1)) == th_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= DIM_W'(RST_W);
			h_q       <= DIM_W'(RST_H);
			twr_q     <= DIM_W'(RST_TWR);
			thr_q     <= DIM_W'(RST_THR);
			tw_q      <= DIM_W'(RST_TW);
			th_q      <= DIM_W'(RST_TH);
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnum_q    <= ACC_W'(RST_W);
			cthr_q    <= ACC_W'(2 * RST_TW);
			rnum_q    <= ACC_W'(RST_H);
			rthr_q    <= ACC_W'(2 * RST_TH);
		end else if (cfg_we) begin
			w_q       <= w_n;
			h_q       <= h_n;
			twr_q     <= twr_n;
			thr_q     <= thr_n;
			tw_q      <= tw_n;
			th_q      <= th_n;
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			cnum_q    <= ACC_W'(w_n);
			cthr_q    <= ACC_W'({tw_n, 1'b0});
			rnum_q    <= ACC_W'(h_n);
			rthr_q    <= ACC_W'({th_n, 1'b0});
		end else if (accept) begin
			if (col_last) begin
				src_col_q <= '0;
				out_col_q <= '0;
				cnum_q    <= ACC_W'(w_q);
				cthr_q    <= ACC_W'({tw_q, 1'b0});
				if (row_last) begin
					src_row_q <= '0;
					out_row_q <= '0;
					rnum_q    <= ACC_W'(h_q);
					rthr_q    <= ACC_W'({th_q, 1'b0});
				end else begin
					src_row_q <= src_row_q + DIM_W'(1);
					rthr_q    <= rthr_q + ACC_W'({th_q, 1'b0});
					if (row_hit) begin
						out_row_q <= out_row_q + DIM_W'(1);
						rnum_q    <= rnum_q + ACC_W'({h_q, 1'b0});
					end
				end
			end else begin
				src_col_q <= src_col_q + DIM_W'(1);
				cthr_q    <= cthr_q + ACC_W'({tw_q, 1'b0});
				if (col_hit) begin
					out_col_q <= out_col_q + DIM_W'(1);
					cnum_q    <= cnum_q + ACC_W'({w_q, 1'b0});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_vld_s1 <= 1'b0;
		end else if (accept) begin
			smp_vld_s1 <= col_hit;
		end else if (take) begin
			smp_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && col_hit) begin
			smp_s1.row_end   <= out_col_last;
			smp_s1.frame_end <= out_col_last && out_row_last;
			smp_s1.red       <= s_tdata[7:0];
			smp_s1.green     <= s_tdata[15:8];
			smp_s1.blue      <= s_tdata[23:16];
		end
	end

	a_src_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		src_col_q < w_q) else $error("source column beyond source width");
	a_out_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_col_q <= tw_q) else $error("output column beyond target width");
	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= th_q) else $error("output row beyond target height");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		smp_vld_s1 && !take |=> smp_vld_s1) else $error("stage 1 beat dropped");

endmodule

// ----- design/ndlg_glyph.sv -----
// ndlg_glyph: luma quantizer, glyph lookup and the output register.
// Takes stage 1 samples from ndlg_sampler. Depends on ndlg_pkg.
`timescale 1ns / 1ps

module ndlg_glyph (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          smp_vld_s1,
	input  ndlg_pkg::sample_t             smp_s1,
	output logic                          take,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ndlg_pkg::OUT_W-1:0]    m_tdata,
	output logic                          m_tlast,
	output logic                          m_tuser
);

	logic [14:0]                    sum;
	logic [17:0]                    sum9;
	logic [ndlg_pkg::LEVEL_W-1:0]   lvl;
	logic [ndlg_pkg::LEVEL_W-1:0]   level_q;
	logic [ndlg_pkg::GLYPH_W-1:0]   glyph_q;
	logic [7:0]                     red_q, green_q, blue_q;
	logic                           row_end_q, frame_end_q;

	always_comb begin
		sum  = 15'(ndlg_pkg::LUMA_R * smp_s1.red + ndlg_pkg::LUMA_G * smp_s1.green
			+ ndlg_pkg::LUMA_B * smp_s1.blue);
		sum9 = 18'({3'b0, sum} * 18'(ndlg_pkg::LEVEL_MUL));
		lvl  = '0;
		for (int k = 1; k <= ndlg_pkg::LEVEL_MAX; k++) begin
			if (sum9 >= 18'(k * ndlg_pkg::LEVEL_DIV)) begin
				lvl = lvl + 4'd1;
			end
		end
	end

	assign take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= smp_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && smp_vld_s1) begin
			level_q     <= lvl;
			glyph_q     <= ndlg_pkg::glyph_of(lvl);
			red_q       <= smp_s1.red;
			green_q     <= smp_s1.green;
			blue_q      <= smp_s1.blue;
			row_end_q   <= smp_s1.row_end;
			frame_end_q <= smp_s1.frame_end;
		end
	end

	assign m_tdata = {5'b0, blue_q, green_q, red_q, level_q, glyph_q};
	assign m_tlast = row_end_q;
	assign m_tuser = frame_end_q;

	a_frame_implies_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("frame end without row end");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> level_q <= 4'(ndlg_pkg::LEVEL_MAX)) else $error("level out of range");

endmodule

// ----- design/nearest_downscale_luma_glyph_core.sv -----
// nearest_downscale_luma_glyph_core: top level of the downscaler that turns RGB pixels
// into text glyphs. Instantiates ndlg_sampler and ndlg_glyph; depends on ndlg_pkg.
`timescale 1ns / 1ps
//
// Usage:
//  - Slave stream s_*: one source pixel per beat in raster order, frame after frame.
//  - Master stream m_*: one glyph beat per sampled pixel (nearest neighbor pick of
//    target_width x target_height out of source_width x source_height).
//    m_tlast marks the last glyph of an output row, m_tuser the last of the frame.
//  - cfg_we/cfg_index/cfg_data write the four size registers (0 source width,
//    1 source height, 2 target width, 3 target height). Any write restarts the
//    frame. Write only while no beats are in flight.
//  - Throughput: one pixel per cycle while s_tready is high, limited by the position
//    counters and accumulators, which step on each accepted beat. A sampled pixel
//    passes the stage 1 register and then the output register to reach m_tvalid.
//  - Reset: sizes return to 640x480 -> 80x24 (clamped to MAX_DIM), counters
//    to frame start, no beat pending.
//  - Stall: with m_tready low the output beat holds; one more sampled pixel
//    waits in stage 1, then s_tready drops. Non-sampled pixels pass freely
//    while stage 1 is empty.

module nearest_downscale_luma_glyph_core #(
	parameter int MAX_DIM = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ndlg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ndlg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ndlg_pkg::IN_W-1:0]     s_tdata,   // red, green, blue
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ndlg_pkg::OUT_W-1:0]    m_tdata,   // glyph_code, level, red_out,
	                                                 // green_out, blue_out, zero pad
	output logic                          m_tlast,   // row_end
	output logic                          m_tuser    // frame_end
);

	logic              take;
	logic              smp_vld_s1;
	ndlg_pkg::sample_t smp_s1;

	ndlg_sampler #(
		.MAX_DIM(MAX_DIM)
	) u_sampler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.take      (take),
		.smp_vld_s1(smp_vld_s1),
		.smp_s1    (smp_s1)
	);

	ndlg_glyph u_glyph (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_vld_s1(smp_vld_s1),
		.smp_s1    (smp_s1),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for nearest_downscale_luma_glyph_core. It streams RGB pixels
// under several size settings and checks each glyph beat against an in-bench predictor.
// Depends on ndlg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

	localparam int DIM_LIMIT = 4096;

	typedef struct packed {
		logic [6:0] code;
		logic [3:0] level;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       frame_end;
	} glyph_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_BLOCKED} rx_mode_t;

	class glyph_scoreboard;
		string ramp = "@%#*+=-:. ";
		logic [12:0] size_reg [4];
		logic [12:0] src_col, src_row, out_col, out_row;
		logic [25:0] col_numer, col_thresh, row_numer, row_thresh;
		glyph_t pending [$];
		int errors;

		function new();
			size_reg[ndlg_pkg::REG_SRC_WIDTH]  = 13'd640;
			size_reg[ndlg_pkg::REG_SRC_HEIGHT] = 13'd480;
			size_reg[ndlg_pkg::REG_TGT_WIDTH]  = 13'd80;
			size_reg[ndlg_pkg::REG_TGT_HEIGHT] = 13'd24;
			errors = 0;
			restart();
		endfunction

		function int unsigned dim(logic [12:0] v);
			if (v == 0)
				return 1;
			if (v > DIM_LIMIT)
				return DIM_LIMIT;
			return v;
		endfunction

		function void sizes(output int unsigned w, h, tw, th);
			w  = dim(size_reg[ndlg_pkg::REG_SRC_WIDTH]);
			h  = dim(size_reg[ndlg_pkg::REG_SRC_HEIGHT]);
			tw = dim(size_reg[ndlg_pkg::REG_TGT_WIDTH]);
			th = dim(size_reg[ndlg_pkg::REG_TGT_HEIGHT]);
			if (tw > w)
				tw = w;
			if (th > h)
				th = h;
		endfunction

		function void restart();
			int unsigned w, h, tw, th;
			sizes(w, h, tw, th);
			src_col = 0;
			src_row = 0;
			out_col = 0;
			out_row = 0;
			col_numer  = 26'(w);
			col_thresh = 26'(2 * tw);
			row_numer  = 26'(h);
			row_thresh = 26'(2 * th);
		endfunction

		function void write_size(logic [ndlg_pkg::IDX_W-1:0] idx, logic [12:0] v);
			size_reg[idx] = v;
			restart();
		endfunction

		function void take_pixel(logic [23:0] px);
			int unsigned w, h, tw, th, luma, lvl;
			logic row_hit, col_hit;
			glyph_t gl;
			sizes(w, h, tw, th);
			row_hit = out_row < th && row_numer < row_thresh;
			col_hit = row_hit && out_col < tw && col_numer < col_thresh;
			if (col_hit) begin
				luma = 28 * px[7:0] + 65 * px[15:8] + 7 * px[23:16];
				lvl = luma * 9 / 25500;
				if (lvl > 9)
					lvl = 9;
				gl.code      = 7'(ramp[lvl]);
				gl.level     = 4'(lvl);
				gl.red       = px[7:0];
				gl.green     = px[15:8];
				gl.blue      = px[23:16];
				gl.row_end   = (out_col + 1 == tw);
				gl.frame_end = (out_col + 1 == tw) && (out_row + 1 == th);
				pending.push_back(gl);
				out_col++;
				col_numer += 26'(2 * w);
			end
			if (src_col + 1 >= w) begin
				src_col = 0;
				out_col = 0;
				col_numer  = 26'(w);
				col_thresh = 26'(2 * tw);
				if (row_hit) begin
					out_row++;
					row_numer += 26'(2 * h);
				end
				row_thresh += 26'(2 * th);
				src_row++;
				if (src_row >= h)
					restart();
			end else begin
				src_col++;
				col_thresh += 26'(2 * tw);
			end
		endfunction

		function string show(glyph_t g);
			return $sformatf("code %0d level %0d rgb %02h/%02h/%02h row_end %b frame_end %b",
				g.code, g.level, g.red, g.green, g.blue, g.row_end, g.frame_end);
		endfunction

		function void check_glyph(logic [ndlg_pkg::OUT_W-1:0] d, logic last, logic user);
			glyph_t got, want;
			got.code      = d[6:0];
			got.level     = d[10:7];
			got.red       = d[18:11];
			got.green     = d[26:19];
			got.blue      = d[34:27];
			got.row_end   = last;
			got.frame_end = user;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: glyph beat with none pending: %s", $realtime, show(got));
				return;
			end
			want = pending.pop_front();
			if (got.code !== want.code || got.level !== want.level ||
			    got.red !== want.red || got.green !== want.green ||
			    got.blue !== want.blue || got.row_end !== want.row_end ||
			    got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= 10)
					$display("%0t: glyph mismatch\n  want %s\n  got  %s",
						$realtime, show(want), show(got));
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ndlg_pkg::IDX_W-1:0]     cfg_index;
	logic [ndlg_pkg::CFG_W-1:0]     cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ndlg_pkg::IN_W-1:0]      s_tdata;   // red, green, blue
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ndlg_pkg::OUT_W-1:0]     m_tdata;   // glyph_code, level, red_out, green_out,
	                                           // blue_out, pad
	logic                           m_tlast;   // row_end
	logic                           m_tuser;   // frame_end

	glyph_scoreboard sb = new();
	int burst_left;
	int rx_left;
	int rx_phase;
	int sent;
	rx_mode_t rx_mode;

	nearest_downscale_luma_glyph_core #(.MAX_DIM(DIM_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("nearest_downscale_luma_glyph_core test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_size(cfg_index, cfg_data);
			if (m_tvalid && m_tready)
				sb.check_glyph(m_tdata, m_tlast, m_tuser);
			if (s_tvalid && s_tready)
				sb.take_pixel(s_tdata);
		end
	end

	// output stall patterns, switched whenever the rx_left countdown runs out
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			RX_OPEN:    m_tready <= 1'b1;
			RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
			RX_QUARTER: m_tready <= (rx_phase % 4 == 0);
			default:    m_tready <= (rx_phase % 10 >= 8);
		endcase
	end

	task automatic send_pixel(input logic [23:0] px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_run(input int n);
		repeat (n) send_pixel(24'($urandom));
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ndlg_pkg::IDX_W-1:0] idx, input logic [12:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
	endtask

	task automatic load_sizes(input logic [12:0] w, h, tw, th, input logic [3:0] mask);
		idle_input();
		wait_drained();
		if (mask[0])
			write_reg(ndlg_pkg::REG_SRC_WIDTH, w);
		if (mask[1])
			write_reg(ndlg_pkg::REG_SRC_HEIGHT, h);
		if (mask[2])
			write_reg(ndlg_pkg::REG_TGT_WIDTH, tw);
		if (mask[3])
			write_reg(ndlg_pkg::REG_TGT_HEIGHT, th);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(output int n);
		logic [12:0] w, h, tw, th;
		logic [3:0] mask;
		int unsigned ew, eh, etw, eth;
		if ($urandom_range(0, 11) == 0) begin
			w = 13'($urandom);
			h = 13'($urandom_range(1, 4));
		end else begin
			w = 13'($urandom_range(1, 20));
			h = 13'($urandom_range(1, 10));
		end
		tw = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, w + 2));
		th = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, h + 2));
		mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
		load_sizes(w, h, tw, th, mask);
		sb.sizes(ew, eh, etw, eth);
		n = $urandom_range(1, 3 * ew * eh);
		if (n > 150)
			n = 150;
		send_run(n);
	endtask

	logic [23:0] swatch [17] = '{
		24'h000000, 24'h1c1c1c, 24'h1d1d1d, 24'h393939, 24'h555555, 24'h727272,
		24'h8e8e8e, 24'haaaaaa, 24'hc7c7c7, 24'he3e3e3, 24'hfefefe, 24'hffffff,
		24'h0000ff, 24'h00ff00, 24'hff0000, 24'h55aa55, 24'haa55aa
	};

	initial begin
		int n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		burst_left = 0;
		rx_left    = 0;
		rx_phase   = 0;
		sent       = 0;
		rx_mode    = RX_OPEN;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset sizes: no glyph before source row 10
		send_run(40);

		// one source row, reset widths kept: 80 glyphs out of 640 pixels
		load_sizes(13'd0, 13'd1, 13'd0, 13'd0, 4'b0010);
		send_run(640);

		// every pixel sampled; gray steps on each level boundary, pure primaries
		load_sizes(13'd4, 13'd2, 13'd4, 13'd2, 4'hF);
		foreach (swatch[i])
			send_pixel(swatch[i]);

		// zero sizes act as one: each pixel ends a row and a frame
		load_sizes(13'd0, 13'd0, 13'd0, 13'd0, 4'hF);
		send_run(4);

		// targets beyond the source clamp to it
		load_sizes(13'd5, 13'd3, 13'd8191, 13'd9, 4'hF);
		send_run(20);

		// widest source row up to its first sample, then tallest source frame
		load_sizes(13'd4096, 13'd1, 13'd7, 13'd8191, 4'hF);
		send_run(300);
		load_sizes(13'd1, 13'd8191, 13'd1, 13'd8191, 4'hF);
		send_run(100);

		while (sent < 1450)
			random_phase(n);

		idle_input();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("nearest_downscale_luma_glyph_core test passed");
		else
			$display("nearest_downscale_luma_glyph_core test failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/ndlg_pkg.sv
design/ndlg_sampler.sv
design/ndlg_glyph.sv
design/nearest_downscale_luma_glyph_core.sv
test/tb.sv
